FILE: hdl/linear_resampler_to_48k_stereo_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the 48 kHz stereo resampler
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef LINEAR_RESAMPLER_TO_48K_STEREO_TOP_MACROS_SVH
`define LINEAR_RESAMPLER_TO_48K_STEREO_TOP_MACROS_SVH

// Same-cycle implication
`define LRS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lrs_pkg.sv
// ---------------------------------------------------------------------------
// lrs_pkg
// Constants, types and command/status structs of the 48 kHz resampler.
// ---------------------------------------------------------------------------
package lrs_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W   = 17;
  // Phase runs up to just below 48000 + 96000 before it is reduced
  localparam int unsigned PHASE_W  = 18;

  localparam logic [RATE_W-1:0] OUT_RATE     = 17'd48000;
  localparam logic [RATE_W-1:0] RATE_MIN     = 17'd7350;
  localparam logic [RATE_W-1:0] RATE_MAX     = 17'd96000;
  localparam logic [RATE_W-1:0] RATE_RESET   = 17'd48000;
  localparam logic [RATE_W:0]   TWO_OUT_RATE = 18'd96000;

  // 48000 = 375 * 2^7: shift by 7, then divide by 375 through a reciprocal
  localparam int unsigned DIV_SHIFT  = 7;
  localparam logic [8:0]  DIV_ODD    = 9'd375;
  localparam int unsigned RECIP_SH   = 33;
  localparam logic [24:0] RECIP_MUL  = 25'd22906492;  // floor(2^33 / 375)

  // Register indexes of the configuration port
  localparam logic CFG_SOURCE_RATE = 1'b0;
  localparam logic CFG_MONO_SOURCE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    PH_HOLD,
    PH_ADD,
    PH_SUB,
    PH_CLR
  } phase_op_e;

  // Controller to datapath
  typedef struct packed {
    logic      load_cur;    // capture the accepted frame
    logic      issue;       // push one output into the interpolator
    logic      sel_interp;  // 1: between held and current frame, 0: current frame
    logic      last;        // last flag of the issued output
    phase_op_e phase_op;
    logic      prev_load;   // current frame becomes the held frame
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pass;          // source rate equals output rate
    logic ph_lt_out;     // phase < 48000
    logic ph_r_gt_2out;  // phase + R > 96000
    logic ph_2r_gt_2out; // phase + 2R > 96000
    logic ph_r_le_out;   // phase + R <= 48000
    logic ph_2r_gt_out;  // phase + 2R > 48000
  } dp_stat_t;

  // One output request into the interpolation pipeline
  typedef struct packed {
    logic                valid;
    sample_t             a_left;
    sample_t             b_left;
    sample_t             a_right;
    sample_t             b_right;
    logic [SAMPLE_W-1:0] phase;
    logic                last;
  } lrs_issue_t;

endpackage

FILE: hdl/lrs_interp.sv
// ---------------------------------------------------------------------------
// lrs_interp
// Six-stage pipeline computing trunc((48000*a + (b-a)*p) / 48000) for both
// channels; the last stage is the output register of the result stream.
// ---------------------------------------------------------------------------
module lrs_interp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lrs_pkg::lrs_issue_t iss_i,
  input  logic                out_ready_i,
  output logic                adv_o,
  output logic                out_valid_o,
  output lrs_pkg::sample_t    out_left_o,
  output lrs_pkg::sample_t    out_right_o,
  output logic                out_last_o
);

  // Valid and last flags of each stage
  logic [5:0] v_q;
  logic [5:0] last_q;

  // Per-channel stage payload (index 0 left, 1 right)
  lrs_pkg::sample_t    a1_q [2];
  logic signed [16:0]  d1_q [2];
  logic [15:0]         p1_q;

  lrs_pkg::sample_t    a2_q [2];
  logic signed [32:0]  q2_q [2];

  lrs_pkg::sample_t    a3_q [2];
  logic [24:0]         x3_q [2];
  logic                neg3_q [2];
  logic                nz3_q [2];

  lrs_pkg::sample_t    a4_q [2];
  logic [24:0]         x4_q [2];
  logic [16:0]         est4_q [2];
  logic                neg4_q [2];
  logic                nz4_q [2];

  lrs_pkg::sample_t    a5_q [2];
  logic [16:0]         fl5_q [2];
  logic                neg5_q [2];
  logic                nz5_q [2];

  lrs_pkg::sample_t    res6_q [2];

  // Combinational per-stage results
  lrs_pkg::sample_t    a_in [2];
  lrs_pkg::sample_t    b_in [2];
  logic signed [16:0]  d_in [2];
  logic signed [33:0]  prod2 [2];
  logic [32:0]         mag3 [2];
  logic [49:0]         prod4 [2];
  logic [25:0]         e375 [2];
  logic [25:0]         rem5w [2];
  logic [9:0]          rem5 [2];
  logic                ge5 [2];
  logic [9:0]          remc5 [2];
  logic [17:0]         flx6 [2];
  logic signed [17:0]  fq6 [2];
  logic signed [17:0]  s6 [2];
  logic signed [17:0]  r6 [2];

  assign adv_o = !v_q[5] || out_ready_i;

  always_comb begin
    a_in[0] = lrs_pkg::sample_t'(iss_i.a_left);
    b_in[0] = lrs_pkg::sample_t'(iss_i.b_left);
    a_in[1] = lrs_pkg::sample_t'(iss_i.a_right);
    b_in[1] = lrs_pkg::sample_t'(iss_i.b_right);
    for (int c = 0; c < 2; c++) begin
      // Stage 1 input: difference of the two frames
      d_in[c]  = $signed({b_in[c][15], b_in[c]}) - $signed({a_in[c][15], a_in[c]});
      // Stage 2 input: scaled difference
      prod2[c] = d1_q[c] * $signed({1'b0, p1_q});
      // Stage 3 input: magnitude
      mag3[c]  = q2_q[c][32] ? 33'(-q2_q[c]) : 33'(q2_q[c]);
      // Stage 4 input: reciprocal estimate of x / 375
      prod4[c] = x3_q[c] * lrs_pkg::RECIP_MUL;
      // Stage 5 input: correct the estimate by one compare and subtract
      e375[c]  = est4_q[c] * lrs_pkg::DIV_ODD;
      rem5w[c] = {1'b0, x4_q[c]} - e375[c];
      rem5[c]  = rem5w[c][9:0];
      ge5[c]   = rem5[c] >= 10'(lrs_pkg::DIV_ODD);
      remc5[c] = ge5[c] ? rem5[c] - 10'(lrs_pkg::DIV_ODD) : rem5[c];
      // Stage 6 input: floor division, then round toward zero
      flx6[c]  = {1'b0, fl5_q[c]} + 18'(nz5_q[c]);
      fq6[c]   = neg5_q[c] ? -$signed(flx6[c]) : $signed({1'b0, fl5_q[c]});
      s6[c]    = $signed({{2{a5_q[c][15]}}, a5_q[c]}) + fq6[c];
      r6[c]    = s6[c] + $signed({17'd0, s6[c][17] & nz5_q[c]});
    end
  end

  // Control of the pipeline: all stages advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_o) begin
      v_q <= {v_q[4:0], iss_i.valid};
    end
  end

  // Payload of the pipeline
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      last_q <= {last_q[4:0], iss_i.last};
      p1_q   <= iss_i.phase;
      for (int c = 0; c < 2; c++) begin
        a1_q[c]   <= a_in[c];
        d1_q[c]   <= d_in[c];
        a2_q[c]   <= a1_q[c];
        q2_q[c]   <= prod2[c][32:0];
        a3_q[c]   <= a2_q[c];
        x3_q[c]   <= mag3[c][31:lrs_pkg::DIV_SHIFT];
        neg3_q[c] <= q2_q[c][32];
        nz3_q[c]  <= |q2_q[c][lrs_pkg::DIV_SHIFT-1:0];
        a4_q[c]   <= a3_q[c];
        x4_q[c]   <= x3_q[c];
        est4_q[c] <= prod4[c][49:lrs_pkg::RECIP_SH];
        neg4_q[c] <= neg3_q[c];
        nz4_q[c]  <= nz3_q[c];
        a5_q[c]   <= a4_q[c];
        fl5_q[c]  <= est4_q[c] + 17'(ge5[c]);
        neg5_q[c] <= neg4_q[c];
        nz5_q[c]  <= nz4_q[c] | (remc5[c] != 10'd0);
        res6_q[c] <= r6[c][15:0];
      end
    end
  end

  assign out_valid_o = v_q[5];
  assign out_last_o  = last_q[5];
  assign out_left_o  = res6_q[0];
  assign out_right_o = res6_q[1];

endmodule

FILE: hdl/lrs_dp.sv
// ---------------------------------------------------------------------------
// lrs_dp
// Datapath: configuration registers, held and current frames, phase
// accumulator with its compares, and the interpolation pipeline.
// ---------------------------------------------------------------------------
module lrs_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [16:0]         cfg_wdata_i,
  input  lrs_pkg::sample_t    first_i,
  input  lrs_pkg::sample_t    second_i,
  input  lrs_pkg::dp_cmd_t    cmd_i,
  output lrs_pkg::dp_stat_t   stat_o,
  input  logic                out_ready_i,
  output logic                adv_o,
  output logic                out_valid_o,
  output lrs_pkg::sample_t    out_left_o,
  output lrs_pkg::sample_t    out_right_o,
  output logic                out_last_o
);

  logic [lrs_pkg::RATE_W-1:0]  rate_q;
  logic                        mono_q;
  logic [lrs_pkg::PHASE_W-1:0] phase_q;
  logic [lrs_pkg::PHASE_W-1:0] phase_d;
  lrs_pkg::sample_t            cur_l_q;
  lrs_pkg::sample_t            cur_r_q;
  lrs_pkg::sample_t            prev_l_q;
  lrs_pkg::sample_t            prev_r_q;

  logic [lrs_pkg::RATE_W-1:0]  rate_c;
  logic [18:0]                 ph_r;
  logic [19:0]                 ph_2r;
  lrs_pkg::lrs_issue_t         iss;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= lrs_pkg::RATE_RESET;
      mono_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lrs_pkg::CFG_SOURCE_RATE: rate_q <= cfg_wdata_i;
        lrs_pkg::CFG_MONO_SOURCE: mono_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Clamp the rate into the supported range
  always_comb begin
    if (rate_q < lrs_pkg::RATE_MIN) begin
      rate_c = lrs_pkg::RATE_MIN;
    end else if (rate_q > lrs_pkg::RATE_MAX) begin
      rate_c = lrs_pkg::RATE_MAX;
    end else begin
      rate_c = rate_q;
    end
  end

  // Lookahead sums of the phase accumulator
  assign ph_r  = {1'b0, phase_q} + {2'b0, rate_c};
  assign ph_2r = {2'b0, phase_q} + {2'b0, rate_c, 1'b0};

  always_comb begin
    stat_o.pass          = rate_q == lrs_pkg::OUT_RATE;
    stat_o.ph_lt_out     = phase_q < 18'(lrs_pkg::OUT_RATE);
    stat_o.ph_r_gt_2out  = ph_r > 19'(lrs_pkg::TWO_OUT_RATE);
    stat_o.ph_2r_gt_2out = ph_2r > 20'(lrs_pkg::TWO_OUT_RATE);
    stat_o.ph_r_le_out   = ph_r <= 19'(lrs_pkg::OUT_RATE);
    stat_o.ph_2r_gt_out  = ph_2r > 20'(lrs_pkg::OUT_RATE);
  end

  // Phase accumulator
  always_comb begin
    case (cmd_i.phase_op)
      lrs_pkg::PH_HOLD: phase_d = phase_q;
      lrs_pkg::PH_ADD:  phase_d = ph_r[lrs_pkg::PHASE_W-1:0];
      lrs_pkg::PH_SUB:  phase_d = phase_q - 18'(lrs_pkg::OUT_RATE);
      lrs_pkg::PH_CLR:  phase_d = '0;
      default:          phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Frame registers; mono copies the first channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur) begin
      cur_l_q <= first_i;
      cur_r_q <= mono_q ? first_i : second_i;
    end
    if (cmd_i.prev_load) begin
      prev_l_q <= cur_l_q;
      prev_r_q <= cur_r_q;
    end
  end

  // Form the interpolation request
  always_comb begin
    iss.valid   = cmd_i.issue;
    iss.a_left  = cmd_i.sel_interp ? prev_l_q : cur_l_q;
    iss.a_right = cmd_i.sel_interp ? prev_r_q : cur_r_q;
    iss.b_left  = cur_l_q;
    iss.b_right = cur_r_q;
    iss.phase   = cmd_i.sel_interp ? phase_q[15:0] : 16'd0;
    iss.last    = cmd_i.last;
  end

  lrs_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_i       (iss),
    .out_ready_i (out_ready_i),
    .adv_o       (adv_o),
    .out_valid_o (out_valid_o),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: hdl/lrs_ctrl.sv
// ---------------------------------------------------------------------------
// lrs_ctrl
// Controller: accepts one frame, walks the output positions between the
// held and the current frame, then repeats the last frame at block end.
// ---------------------------------------------------------------------------
`include "linear_resampler_to_48k_stereo_top_macros.svh"

module lrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_end_i,
  input  logic              adv_i,
  input  lrs_pkg::dp_stat_t stat_i,
  output lrs_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_REPEAT
  } state_e;

  state_e state_q, state_d;
  logic   end_q, end_d;
  logic   hold_q, hold_d;  // a frame is held
  logic   accept;

  assign in_ready_o = state_q == ST_IDLE;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    end_d   = end_q;
    hold_d  = hold_q;
    cmd_o   = '{load_cur: 1'b0, issue: 1'b0, sel_interp: 1'b0, last: 1'b0,
                phase_op: lrs_pkg::PH_HOLD, prev_load: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load_cur = 1'b1;
          end_d          = in_end_i;
          state_d        = ST_INTERP;
        end
      end
      ST_INTERP: begin
        if (stat_i.pass) begin
          // Pass the frame straight through
          if (adv_i) begin
            cmd_o.issue     = 1'b1;
            cmd_o.last      = end_q;
            cmd_o.phase_op  = lrs_pkg::PH_CLR;
            cmd_o.prev_load = 1'b1;
            hold_d          = !end_q;
            state_d         = ST_IDLE;
          end
        end else if (hold_q && stat_i.ph_lt_out) begin
          if (end_q && stat_i.ph_r_gt_2out) begin
            // Block ends before the next position
            cmd_o.phase_op = lrs_pkg::PH_CLR;
            hold_d         = 1'b0;
            state_d        = ST_IDLE;
          end else if (adv_i) begin
            cmd_o.issue      = 1'b1;
            cmd_o.sel_interp = 1'b1;
            cmd_o.last       = end_q && stat_i.ph_2r_gt_2out;
            cmd_o.phase_op   = lrs_pkg::PH_ADD;
          end
        end else begin
          // Move on to the next source frame
          if (hold_q) begin
            cmd_o.phase_op = lrs_pkg::PH_SUB;
          end
          cmd_o.prev_load = 1'b1;
          hold_d          = 1'b1;
          state_d         = end_q ? ST_REPEAT : ST_IDLE;
        end
      end
      ST_REPEAT: begin
        if (stat_i.ph_r_le_out) begin
          if (adv_i) begin
            cmd_o.issue    = 1'b1;
            cmd_o.last     = stat_i.ph_2r_gt_out;
            cmd_o.phase_op = lrs_pkg::PH_ADD;
          end
        end else begin
          // Drop the block state
          cmd_o.phase_op = lrs_pkg::PH_CLR;
          hold_d         = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
      hold_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      hold_q  <= hold_d;
    end
  end

  `LRS_ASSERT_NOW(a_issue_not_idle, clk_i, rst_ni, state_q == ST_IDLE, !cmd_o.issue, "issue while idle")
  `LRS_ASSERT_NOW(a_issue_on_adv, clk_i, rst_ni, cmd_o.issue, adv_i, "issue into stalled pipeline")
  `LRS_ASSERT_NEXT(a_accept_runs, clk_i, rst_ni, accept, state_q == ST_INTERP, "accept did not start")

endmodule

FILE: hdl/linear_resampler_to_48k_stereo_top.sv
// ---------------------------------------------------------------------------
// linear_resampler_to_48k_stereo_top
// Linear-interpolation resampler from a configurable source rate to 48 kHz
// stereo, with an exact phase accumulator.
//
//   Channel   Dir  Handshake        Payload
//   s_axis    in   tvalid/tready    tdata: first, second channel; tlast: end
//   m_axis    out  tvalid/tready    tdata: left, right; tlast: last of block
//   cfg       in   cfg_we_i         cfg_index_i, cfg_wdata_i
//
// Each source frame is accepted while idle, then its interpolated outputs
// are issued; a block end that reaches the repeat step then issues the
// repeated outputs. At equal rates each frame passes as one output.
// No new frame is accepted until then. Outputs leave a registered pipeline.
// A stalled m_axis freezes the whole pipeline and the issue loop.
// Reset drops the held frame, clears the phase and mono; rate resets to 48000.
// ---------------------------------------------------------------------------
module linear_resampler_to_48k_stereo_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] first_channel, [31:16] second_channel
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] left_out, [31:16] right_out
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [16:0] cfg_wdata_i
);

  lrs_pkg::dp_cmd_t  cmd;
  lrs_pkg::dp_stat_t stat;
  logic              adv;
  lrs_pkg::sample_t  left;
  lrs_pkg::sample_t  right;

  lrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_end_i   (s_axis_tlast),
    .adv_i      (adv),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lrs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .first_i     (s_axis_tdata[15:0]),
    .second_i    (s_axis_tdata[31:16]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .adv_o       (adv),
    .out_valid_o (m_axis_tvalid),
    .out_left_o  (left),
    .out_right_o (right),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {right, left};

endmodule
